[rtl/slc_pkg.sv]
`default_nettype none
package slc_pkg;
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_FILL  = 2'd2;
  localparam logic [1:0] MODE_FLUSH = 2'd3;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;
  localparam logic [1:0] SIZE_BAD  = 2'd3;

  localparam logic [2:0] STAT_HIT        = 3'd0;
  localparam logic [2:0] STAT_MISS       = 3'd1;
  localparam logic [2:0] STAT_FLUSHED    = 3'd2;
  localparam logic [2:0] STAT_NONE       = 3'd3;
  localparam logic [2:0] STAT_MISALIGNED = 3'd4;

  localparam logic [1:0]  OFFSET_LAST = 2'd3;
  localparam logic [31:0] ALL_ONES    = 32'hffff_ffff;
  localparam logic [31:0] BYTE_MASK   = 32'h0000_00ff;
  localparam logic [31:0] HALF_MASK   = 32'h0000_ffff;
endpackage
`default_nettype wire

[rtl/slc_req_if.sv]
`default_nettype none
interface slc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] address;
  logic [31:0] data;
  logic [1:0]  size_code;
  modport source (output valid, mode, address, data, size_code, input ready);
  modport sink   (input valid, mode, address, data, size_code, output ready);
endinterface
`default_nettype wire

[rtl/slc_rsp_if.sv]
`default_nettype none
interface slc_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] out_data;
  logic [31:0] mem_address;
  logic        last;
  modport source (output valid, status, out_data, mem_address, last, input ready);
  modport sink   (input valid, status, out_data, mem_address, last, output ready);
endinterface
`default_nettype wire

[rtl/slc_ram.sv]
`default_nettype none
module slc_ram #(
  parameter int WIDTH = 32,
  parameter int AW    = 8
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic             re,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [1<<AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end
endmodule
`default_nettype wire

[rtl/slc_way_select.sv]
`default_nettype none
module slc_way_select #(
  parameter int TAG_W     = 21,
  parameter int WAY_COUNT = 4,
  parameter int WAY_BITS  = 2,
  localparam int ENTRY_W  = TAG_W + 33
) (
  input  wire logic [WAY_COUNT*ENTRY_W-1:0] row,
  input  wire logic [TAG_W-1:0]             tag,
  output logic                              hit,
  output logic [WAY_BITS-1:0]               hit_way,
  output logic [WAY_BITS-1:0]               fill_way,
  output logic [WAY_BITS-1:0]               old_way
);
  localparam int P = 1 << WAY_BITS;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             valid;
    logic [31:0]      age;
  } entry_t;

  entry_t [WAY_COUNT-1:0] e;
  logic                   inv_found;
  logic [WAY_BITS-1:0]    inv_way;
  logic [31:0]            ag [WAY_BITS+1][P];
  logic [WAY_BITS-1:0]    ix [WAY_BITS+1][P];

  assign e = row;

  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    inv_found = 1'b0;
    inv_way   = '0;
    for (int k = 0; k < WAY_COUNT; k++) begin
      if (!hit && e[k].valid && e[k].tag == tag) begin
        hit     = 1'b1;
        hit_way = WAY_BITS'(k);
      end
      if (!inv_found && !e[k].valid) begin
        inv_found = 1'b1;
        inv_way   = WAY_BITS'(k);
      end
    end
    // oldest way: pairwise tree, right side wins only when strictly older
    for (int l = 0; l <= WAY_BITS; l++) begin
      for (int n = 0; n < P; n++) begin
        ag[l][n] = '0;
        ix[l][n] = '0;
      end
    end
    for (int n = 0; n < P; n++) begin
      ix[0][n] = WAY_BITS'(n);
      if (n < WAY_COUNT) begin
        ag[0][n] = e[n].age;
      end
    end
    for (int l = 0; l < WAY_BITS; l++) begin
      for (int n = 0; n < (P >> (l + 1)); n++) begin
        if (ag[l][2*n+1] > ag[l][2*n]) begin
          ag[l+1][n] = ag[l][2*n+1];
          ix[l+1][n] = ix[l][2*n+1];
        end else begin
          ag[l+1][n] = ag[l][2*n];
          ix[l+1][n] = ix[l][2*n];
        end
      end
    end
    old_way  = ix[WAY_BITS][0];
    fill_way = hit ? hit_way : (inv_found ? inv_way : old_way);
  end
endmodule
`default_nettype wire

[rtl/set_associative_lru_cache_unit.sv]
`default_nettype none
// Set-associative cache with per-way 32-bit age counters and oldest-way
// replacement. Each request word (read, write on hit, fill with allocation,
// flush of the oldest way of a set) yields one response word, except a flush
// of a valid way, which yields one word per line word with its memory address;
// last marks the final one. Tags, valid bits and ages of a whole set sit in one
// row of a set memory; line data sits in a word-wide data memory. A request is
// accepted in ST_IDLE together with the set-row read and decided in ST_LOOK; a
// read or write hit then goes on to ST_ACCESS for the data read and write-back.
// A flush of a valid way goes on from ST_LOOK to ST_FLUSH, streaming one word
// per cycle while the receiver takes them. A new request is taken only in ST_IDLE.
// A stalled response holds the block in place until the word is taken.
// After reset a clearing pass walks every data-memory address and zeroes both
// memories; no request is taken during it.
module set_associative_lru_cache_unit #(
  parameter int SET_BITS  = 6,
  parameter int WAY_COUNT = 4,
  parameter int WORD_BITS = 3
) (
  input wire logic clk,
  input wire logic rst,
  slc_req_if.sink  req,
  slc_rsp_if.source rsp
);
  import slc_pkg::*;

  localparam int TAG_SHIFT = SET_BITS + WORD_BITS + 2;
  localparam int TAG_W     = 32 - TAG_SHIFT;
  localparam int WAY_BITS  = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int WB1       = (WORD_BITS > 0) ? WORD_BITS : 1;
  localparam int DAW       = SET_BITS + WAY_BITS + WORD_BITS;
  localparam int ENTRY_W   = TAG_W + 33;
  localparam int ROW_W     = WAY_COUNT * ENTRY_W;
  localparam logic [WB1-1:0] WORD_MASK = WB1'((1 << WORD_BITS) - 1);

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             valid;
    logic [31:0]      age;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_LOOK, ST_ACCESS, ST_FLUSH
  } state_t;

  state_t         state, state_next;
  logic [DAW-1:0] clr_cnt;
  logic [1:0]     mode_q, size_q;
  logic [31:0]    addr_q, data_q;
  logic [WAY_BITS-1:0] way_q, way_next;
  logic [WB1-1:0] cnt, cnt_next;

  // set memory port
  logic                s_we, s_re;
  logic [SET_BITS-1:0] s_addr;
  logic [ROW_W-1:0]    s_wdata, s_rdata;
  // data memory port
  logic           d_we, d_re;
  logic [DAW-1:0] d_addr;
  logic [31:0]    d_wdata, d_rdata;

  entry_t [WAY_COUNT-1:0] row, row_upd, row_inv;
  logic                hit;
  logic [WAY_BITS-1:0] hit_way, fill_way, old_way, upd_way;

  logic [SET_BITS-1:0] set_q;
  logic [TAG_W-1:0]    tag_q;
  logic [WB1-1:0]      word_q;
  logic [1:0]          boff;
  logic [4:0]          sh;
  logic [31:0]         nmask, rd_val, wr_val;
  logic                bad;

  // response register
  logic        out_free;
  logic        res_load;
  logic [2:0]  res_status;
  logic [31:0] res_data, res_maddr;
  logic        res_last;

  function automatic logic [DAW-1:0] mk_daddr(input logic [SET_BITS-1:0] s,
                                              input logic [WAY_BITS-1:0] w,
                                              input logic [WB1-1:0] wd);
    return (DAW'(s) << (WAY_BITS + WORD_BITS)) | (DAW'(w) << WORD_BITS)
         | DAW'(wd & WORD_MASK);
  endfunction

  slc_ram #(.WIDTH(ROW_W), .AW(SET_BITS)) u_set_mem (
    .clk(clk), .we(s_we), .re(s_re), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata)
  );

  slc_ram #(.WIDTH(32), .AW(DAW)) u_data_mem (
    .clk(clk), .we(d_we), .re(d_re), .addr(d_addr), .wdata(d_wdata), .rdata(d_rdata)
  );

  assign row = s_rdata;

  slc_way_select #(.TAG_W(TAG_W), .WAY_COUNT(WAY_COUNT), .WAY_BITS(WAY_BITS)) u_sel (
    .row(s_rdata), .tag(tag_q), .hit(hit), .hit_way(hit_way),
    .fill_way(fill_way), .old_way(old_way)
  );

  assign set_q  = addr_q[WORD_BITS+2 +: SET_BITS];
  assign tag_q  = addr_q[31 -: TAG_W];
  assign word_q = WB1'(addr_q >> 2) & WORD_MASK;
  assign boff   = addr_q[1:0];
  assign sh     = {boff, 3'b000};
  assign bad    = (size_q == SIZE_BAD) || (size_q == SIZE_HALF && boff == OFFSET_LAST);
  assign nmask  = (size_q == SIZE_BYTE) ? BYTE_MASK : HALF_MASK;
  assign rd_val = (size_q == SIZE_WORD) ? d_rdata : ((d_rdata >> sh) & nmask);
  assign wr_val = (size_q == SIZE_WORD) ? data_q
                : ((d_rdata & ~(nmask << sh)) | ((data_q & nmask) << sh));

  assign req.ready = (state == ST_IDLE);
  assign out_free  = !rsp.valid || rsp.ready;
  assign upd_way   = (state == ST_LOOK) ? fill_way : way_q;

  // age touch: used way to zero, the rest one older; fill also claims the way
  always_comb begin
    row_upd = row;
    row_inv = row;
    for (int k = 0; k < WAY_COUNT; k++) begin
      if (WAY_BITS'(k) == upd_way) begin
        row_upd[k].age = '0;
        if (state == ST_LOOK) begin
          row_upd[k].tag   = tag_q;
          row_upd[k].valid = 1'b1;
        end
      end else begin
        row_upd[k].age = row[k].age + 32'd1;
      end
      if (WAY_BITS'(k) == way_q) begin
        row_inv[k].valid = 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    way_next   = way_q;
    cnt_next   = cnt;
    s_we = 1'b0; s_re = 1'b0; s_addr = set_q; s_wdata = row_upd;
    d_we = 1'b0; d_re = 1'b0; d_addr = mk_daddr(set_q, way_q, word_q); d_wdata = wr_val;
    res_load = 1'b0; res_status = STAT_HIT; res_data = '0; res_maddr = '0; res_last = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        s_we    = 1'b1;
        s_addr  = clr_cnt[DAW-1 -: SET_BITS];
        s_wdata = '0;
        d_we    = 1'b1;
        d_addr  = clr_cnt;
        d_wdata = '0;
        if (&clr_cnt) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req.valid) begin
          s_re       = 1'b1;
          s_addr     = req.address[WORD_BITS+2 +: SET_BITS];
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (out_free) begin
          state_next = ST_IDLE;
          if (mode_q == MODE_FLUSH) begin
            if (!row[old_way].valid) begin
              res_load   = 1'b1;
              res_status = STAT_NONE;
            end else begin
              way_next   = old_way;
              cnt_next   = '0;
              d_re       = 1'b1;
              d_addr     = mk_daddr(set_q, old_way, '0);
              state_next = ST_FLUSH;
            end
          end else if (mode_q == MODE_FILL) begin
            d_we     = 1'b1;
            d_addr   = mk_daddr(set_q, fill_way, word_q);
            d_wdata  = data_q;
            s_we     = 1'b1;
            res_load = 1'b1;
          end else if (bad) begin
            res_load   = 1'b1;
            res_status = STAT_MISALIGNED;
          end else if (!hit) begin
            res_load   = 1'b1;
            res_status = STAT_MISS;
            res_data   = (mode_q == MODE_READ) ? ALL_ONES : '0;
          end else begin
            way_next   = hit_way;
            d_re       = 1'b1;
            d_addr     = mk_daddr(set_q, hit_way, word_q);
            state_next = ST_ACCESS;
          end
        end
      end
      ST_ACCESS: begin
        if (out_free) begin
          res_load   = 1'b1;
          res_data   = (mode_q == MODE_READ) ? rd_val : '0;
          d_we       = (mode_q == MODE_WRITE);
          s_we       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          res_load   = 1'b1;
          res_status = STAT_FLUSHED;
          res_data   = d_rdata;
          res_maddr  = (32'(row[way_q].tag) << TAG_SHIFT)
                     | (32'(set_q) << (WORD_BITS + 2)) | (32'(cnt) << 2);
          res_last   = (cnt == WORD_MASK);
          if (cnt == WORD_MASK) begin
            s_we       = 1'b1;
            s_wdata    = row_inv;
            state_next = ST_IDLE;
          end else begin
            cnt_next = cnt + WB1'(1);
            d_re     = 1'b1;
            d_addr   = mk_daddr(set_q, way_q, cnt + WB1'(1));
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + DAW'(1);
      end
      if (out_free) begin
        rsp.valid <= res_load;
      end
    end
    if (req.valid && req.ready) begin
      mode_q <= req.mode;
      addr_q <= req.address;
      data_q <= req.data;
      size_q <= req.size_code;
    end
    way_q <= way_next;
    cnt   <= cnt_next;
    if (res_load) begin
      rsp.status      <= res_status;
      rsp.out_data    <= res_data;
      rsp.mem_address <= res_maddr;
      rsp.last        <= res_last;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst) res_load |-> out_free)
    else $error("response loaded over an untaken word");
  a_flush_word: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH && out_free) |-> res_load)
    else $error("flush cycle without a response word");
  a_flush_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |-> row[way_q].valid)
    else $error("flushing an invalid way");
  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |=> !(rsp.valid))
    else $error("response during clearing pass");
endmodule
`default_nettype wire

[test/tb_set_associative_lru_cache_unit.sv]
`default_nettype none
module tb_set_associative_lru_cache_unit;
  import slc_pkg::*;

  // geometry at the block's default parameters
  localparam int SET_BITS   = 6;
  localparam int WAY_COUNT  = 4;
  localparam int WORD_BITS  = 3;
  localparam int LINE_LEN   = 1 << WORD_BITS;
  localparam int SLOT_COUNT = (1 << SET_BITS) * WAY_COUNT;
  localparam int TAG_SHIFT  = SET_BITS + WORD_BITS + 2;
  localparam int TAG_W      = 32 - TAG_SHIFT;

  localparam int RANDOM_ITEMS = 96;
  localparam int CALM_TAIL    = 20;      // last items run with no idling
  localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_data;
    logic [31:0] mem_address;
    logic        last;
  } rsp_word_t;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] address;
    logic [31:0] data;
    logic [1:0]  size_code;
    bit          typed;      // expected first word given in the row
    logic [2:0]  typed_status;
    logic [31:0] typed_data;
  } stim_row_t;

  logic clk;
  logic rst;
  slc_req_if req_ch();
  slc_rsp_if rsp_ch();

  set_associative_lru_cache_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // shadow copy of the cache contents
  logic [31:0]      line_mem [LINE_LEN*SLOT_COUNT];
  logic [TAG_W-1:0] tag_mem  [SLOT_COUNT];
  logic             vld_mem  [SLOT_COUNT];
  logic [31:0]      age_mem  [SLOT_COUNT];

  rsp_word_t pending_rsp[$];
  stim_row_t dir_rows[$];
  int        fail_count;
  int        rsp_seen;
  int        cycle_count;
  bit        calm;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int oldest_way(int base);
    int w;
    w = 0;
    for (int i = 1; i < WAY_COUNT; i++)
      if (age_mem[base+i] > age_mem[base+w]) w = i;
    return w;
  endfunction

  function automatic int find_way(int base, logic [TAG_W-1:0] tg);
    for (int i = 0; i < WAY_COUNT; i++)
      if (vld_mem[base+i] && tag_mem[base+i] == tg) return i;
    return -1;
  endfunction

  // hit or fill: used way goes young, the rest age by one (wrapping)
  task automatic touch_way(int base, int way);
    for (int i = 0; i < WAY_COUNT; i++)
      age_mem[base+i] = (i == way) ? 32'd0 : age_mem[base+i] + 32'd1;
  endtask

  task automatic push_rsp(logic [2:0] st, logic [31:0] d, logic [31:0] ma, logic lst);
    rsp_word_t r;
    r.status = st;
    r.out_data = d;
    r.mem_address = ma;
    r.last = lst;
    pending_rsp.push_back(r);
  endtask

  // updates the shadow cache for one accepted request and queues its responses
  task automatic cache_predict(logic [1:0] mode, logic [31:0] addr, logic [31:0] data,
                               logic [1:0] size);
    logic [1:0]       boff;
    int               wd, st, base, way, slot, cell_ix;
    logic [TAG_W-1:0] tg;
    logic [31:0]      mask, cur_word, line_addr;
    boff = addr[1:0];
    wd   = addr[WORD_BITS+1:2];
    st   = addr[TAG_SHIFT-1:WORD_BITS+2];
    tg   = addr[31:TAG_SHIFT];
    base = st * WAY_COUNT;
    if (mode == MODE_FLUSH) begin
      slot = base + oldest_way(base);
      if (!vld_mem[slot]) begin
        push_rsp(STAT_NONE, 32'd0, 32'd0, 1'b1);
      end else begin
        line_addr = ({{TAG_SHIFT{1'b0}}, tag_mem[slot]} << TAG_SHIFT) |
                    (32'(st) << (WORD_BITS + 2));
        for (int i = 0; i < LINE_LEN; i++)
          push_rsp(STAT_FLUSHED, line_mem[slot*LINE_LEN+i], line_addr + 32'(i*4),
                   i == LINE_LEN-1);
        vld_mem[slot] = 1'b0;
      end
    end else if (mode == MODE_FILL) begin
      way = find_way(base, tg);
      if (way < 0) begin
        for (int i = WAY_COUNT-1; i >= 0; i--)
          if (!vld_mem[base+i]) way = i;
        if (way < 0) way = oldest_way(base);
      end
      line_mem[(base+way)*LINE_LEN+wd] = data;
      tag_mem[base+way] = tg;
      vld_mem[base+way] = 1'b1;
      touch_way(base, way);
      push_rsp(STAT_HIT, 32'd0, 32'd0, 1'b1);
    end else if (size == SIZE_BAD || (size == SIZE_HALF && boff == OFFSET_LAST)) begin
      push_rsp(STAT_MISALIGNED, 32'd0, 32'd0, 1'b1);
    end else begin
      way = find_way(base, tg);
      if (way < 0) begin
        push_rsp(STAT_MISS, (mode == MODE_READ) ? ALL_ONES : 32'd0, 32'd0, 1'b1);
      end else begin
        cell_ix = (base+way)*LINE_LEN + wd;
        cur_word = line_mem[cell_ix];
        mask = (size == SIZE_BYTE) ? BYTE_MASK : HALF_MASK;
        if (mode == MODE_READ) begin
          push_rsp(STAT_HIT,
                   (size == SIZE_WORD) ? cur_word : ((cur_word >> (boff*8)) & mask),
                   32'd0, 1'b1);
        end else begin
          if (size == SIZE_WORD)
            line_mem[cell_ix] = data;
          else
            line_mem[cell_ix] = (cur_word & ~(mask << (boff*8))) |
                                ((data & mask) << (boff*8));
          push_rsp(STAT_HIT, 32'd0, 32'd0, 1'b1);
        end
        touch_way(base, way);
      end
    end
  endtask

  // offers one request word and holds it until the block takes it
  task automatic send_req(logic [1:0] mode, logic [31:0] addr, logic [31:0] data,
                          logic [1:0] size);
    req_ch.valid     <= 1'b1;
    req_ch.mode      <= mode;
    req_ch.address   <= addr;
    req_ch.data      <= data;
    req_ch.size_code <= size;
    do @(posedge clk); while (!req_ch.ready);
    cache_predict(mode, addr, data, size);
  endtask

  // random gap after a word; valid dropped only when a gap really follows
  task automatic req_gap();
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    logic [1:0] mode, size;
    logic [31:0] addr;
    int         pick;
    fail_count = 0;
    calm = 1'b0;
    rst <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.mode      <= MODE_READ;
    req_ch.address   <= 32'd0;
    req_ch.data      <= 32'd0;
    req_ch.size_code <= SIZE_BYTE;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      tag_mem[s] = '0;
      vld_mem[s] = 1'b0;
      age_mem[s] = 32'd0;
    end
    for (int s = 0; s < LINE_LEN*SLOT_COUNT; s++) line_mem[s] = 32'd0;

    // directed rows; typed rows are known without any cache state
    dir_rows.push_back('{MODE_READ,  32'h0000_1234, 32'd0, SIZE_WORD, 1, STAT_MISS, ALL_ONES});
    dir_rows.push_back('{MODE_FLUSH, 32'h0000_0000, 32'd0, SIZE_WORD, 1, STAT_NONE, 32'd0});
    dir_rows.push_back('{MODE_READ,  32'h0000_0003, 32'd0, SIZE_HALF, 1,
                         STAT_MISALIGNED, 32'd0});
    dir_rows.push_back('{MODE_WRITE, 32'h0000_0000, ALL_ONES, SIZE_BAD, 1,
                         STAT_MISALIGNED, 32'd0});
    dir_rows.push_back('{MODE_FILL,  32'h0000_0000, 32'ha1b2_c3d4, SIZE_WORD, 0, 0, 0});
    dir_rows.push_back('{MODE_FILL,  32'h0000_0004, ALL_ONES, SIZE_BAD, 0, 0, 0});
    dir_rows.push_back('{MODE_READ,  32'h0000_0001, 32'd0, SIZE_BYTE, 0, 0, 0});
    dir_rows.push_back('{MODE_READ,  32'h0000_0002, 32'd0, SIZE_HALF, 0, 0, 0});
    dir_rows.push_back('{MODE_READ,  32'h0000_0003, 32'd0, SIZE_WORD, 0, 0, 0});
    dir_rows.push_back('{MODE_WRITE, 32'h0000_0003, 32'hffff_ff5a, SIZE_BYTE, 0, 0, 0});
    dir_rows.push_back('{MODE_WRITE, 32'h0000_0000, 32'h1234_beef, SIZE_HALF, 0, 0, 0});
    dir_rows.push_back('{MODE_WRITE, 32'h0000_0006, 32'h1234_5678, SIZE_WORD, 0, 0, 0});
    dir_rows.push_back('{MODE_READ,  32'h0000_0000, 32'd0, SIZE_WORD, 0, 0, 0});
    dir_rows.push_back('{MODE_FILL,  32'h0000_0800, 32'h0000_0001, SIZE_WORD, 0, 0, 0});
    dir_rows.push_back('{MODE_FILL,  32'h0000_1000, 32'h0000_0002, SIZE_WORD, 0, 0, 0});
    dir_rows.push_back('{MODE_FILL,  32'h0000_1800, 32'h0000_0003, SIZE_WORD, 0, 0, 0});
    // all four ways valid: this one evicts the oldest
    dir_rows.push_back('{MODE_FILL,  32'hffff_f800, 32'h8000_0000, SIZE_WORD, 0, 0, 0});
    dir_rows.push_back('{MODE_READ,  32'hffff_f800, 32'd0, SIZE_WORD, 0, 0, 0});
    dir_rows.push_back('{MODE_WRITE, 32'h0000_2000, 32'hdead_beef, SIZE_WORD, 1,
                         STAT_MISS, 32'd0});
    dir_rows.push_back('{MODE_FLUSH, 32'h0000_0000, 32'd0, SIZE_WORD, 0, 0, 0});
    dir_rows.push_back('{MODE_READ,  32'hffff_ffff, 32'd0, SIZE_BYTE, 1, STAT_MISS, ALL_ONES});
    dir_rows.push_back('{MODE_FILL,  32'hffff_ffff, 32'd0, SIZE_HALF, 0, 0, 0});
    dir_rows.push_back('{MODE_READ,  32'hffff_fffe, 32'd0, SIZE_HALF, 0, 0, 0});
    dir_rows.push_back('{MODE_FLUSH, 32'hffff_ffff, 32'd0, SIZE_BAD, 0, 0, 0});

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // typed rows all give a single word, so it is the newest one queued
    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].mode, dir_rows[i].address, dir_rows[i].data,
               dir_rows[i].size_code);
      if (dir_rows[i].typed &&
          (pending_rsp[$].status !== dir_rows[i].typed_status ||
           pending_rsp[$].out_data !== dir_rows[i].typed_data)) begin
        $error("row %0d: typed status/out_data %0d/%h, predicted %0d/%h", i,
               dir_rows[i].typed_status, dir_rows[i].typed_data,
               pending_rsp[$].status, pending_rsp[$].out_data);
        fail_count++;
      end
      req_gap();
    end

    // sender pause until everything so far has come back
    req_ch.valid <= 1'b0;
    wait_drained();
    @(posedge clk);

    // random part: addresses mostly hit a few sets and tags so lines get reused
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= RANDOM_ITEMS - CALM_TAIL) calm = 1'b1;
      pick = $urandom_range(0, 9);
      mode = (pick < 3) ? MODE_READ : (pick < 5) ? MODE_WRITE :
             (pick < 8) ? MODE_FILL : MODE_FLUSH;
      addr = $urandom();
      if ($urandom_range(0, 4) != 0) begin
        addr[31:TAG_SHIFT] = (addr[31] ? {TAG_W{1'b1}} : {TAG_W{1'b0}}) ^
                             TAG_W'($urandom_range(0, 5));
        addr[TAG_SHIFT-1:WORD_BITS+2] = SET_BITS'($urandom_range(0, 2));
      end
      size = ($urandom_range(0, 9) == 0) ? SIZE_BAD : 2'($urandom_range(0, 2));
      send_req(mode, addr, $urandom(), size);
      req_gap();
    end
    req_ch.valid <= 1'b0;

    wait_drained();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_set_associative_lru_cache_unit passed");
    end else begin
      $display("tb_set_associative_lru_cache_unit failed");
    end
    $finish;
  end

  // response side: random bursts of stall, one long hold-off while requests keep coming
  initial begin
    bit held;
    held = 1'b0;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!held && rsp_seen >= 40) begin
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // response checker: each word against the oldest prediction
  initial begin
    rsp_word_t want;
    rsp_seen = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        rsp_seen++;
        if (pending_rsp.size() == 0) begin
          $error("response word with nothing pending: status %0d", rsp_ch.status);
          fail_count++;
        end else begin
          want = pending_rsp.pop_front();
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
            fail_count++;
          end
          if (rsp_ch.out_data !== want.out_data) begin
            $error("out_data: expected %h, got %h", want.out_data, rsp_ch.out_data);
            fail_count++;
          end
          if (rsp_ch.mem_address !== want.mem_address) begin
            $error("mem_address: expected %h, got %h", want.mem_address,
                   rsp_ch.mem_address);
            fail_count++;
          end
          if (rsp_ch.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, rsp_ch.last);
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog; covers the clearing pass after reset with room to spare
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_set_associative_lru_cache_unit failed");
    $finish;
  end
endmodule
`default_nettype wire
